>>> rtl/npcs_pkg.sv
`default_nettype none

package npcs_pkg;

    localparam int DEFAULT_PALETTE_ENTRIES = 256;
    localparam int ENTRY_IDX_W             = 8;
    localparam int CHAN_W                  = 16;
    localparam int SQ_W                    = 2 * CHAN_W;
    localparam int SUM_W                   = SQ_W + 2;
    localparam int PIXEL_W                 = 32;
    localparam int INDEXED_CELLS           = 255;
    localparam int DIRECT_ADD_CELLS        = 16;
    localparam int DIRECT_OR_CELLS         = 256;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_MASK    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_MASK  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BLUE_MASK   = 2'd3;

    localparam logic [1:0] MODE_INDEXED    = 2'd0;
    localparam logic [1:0] MODE_DIRECT_ADD = 2'd1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 88;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              excl;
    } entry_t;

    typedef struct packed {
        logic                   valid;
        logic                   skip;
        logic [ENTRY_IDX_W-1:0] idx;
        logic [CHAN_W-1:0]      red;
        logic [CHAN_W-1:0]      green;
        logic [CHAN_W-1:0]      blue;
        logic [SQ_W-1:0]        sq_red;
        logic [SQ_W-1:0]        sq_green;
        logic [SQ_W-1:0]        sq_blue;
    } dist_t;

    typedef struct packed {
        logic                   found;
        logic [ENTRY_IDX_W-1:0] idx_red;
        logic [ENTRY_IDX_W-1:0] idx_green;
        logic [ENTRY_IDX_W-1:0] idx_blue;
        logic [CHAN_W-1:0]      red;
        logic [CHAN_W-1:0]      green;
        logic [CHAN_W-1:0]      blue;
    } best_t;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [PIXEL_W-1:0] low_bit(input logic [PIXEL_W-1:0] m);
        return m & (~m + 32'd1);
    endfunction

endpackage

`default_nettype wire

>>> rtl/npcs_cell.sv
`default_nettype none

module npcs_cell
    import npcs_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   shift_en,
    input  wire logic   load_en,
    input  wire entry_t shift_in,
    input  wire entry_t load_data,
    output entry_t      entry_q
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (shift_en) begin
            entry_next = shift_in;
        end else if (load_en) begin
            entry_next = load_data;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_q = entry_reg;

endmodule

`default_nettype wire

>>> rtl/npcs_dist.sv
`default_nettype none

module npcs_dist
    import npcs_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    input  wire logic                   honor_excl,
    input  wire logic [ENTRY_IDX_W-1:0] in_idx,
    input  wire entry_t                 head,
    input  wire logic [CHAN_W-1:0]      target_red,
    input  wire logic [CHAN_W-1:0]      target_green,
    input  wire logic [CHAN_W-1:0]      target_blue,
    output dist_t                       dist_q
);

    dist_t dist_reg;
    dist_t dist_next;
    logic [CHAN_W-1:0] dr, dg, db;

    always_comb begin
        dr = abs_diff(target_red, head.red);
        dg = abs_diff(target_green, head.green);
        db = abs_diff(target_blue, head.blue);
        dist_next.valid    = in_valid;
        dist_next.skip     = honor_excl & head.excl;
        dist_next.idx      = in_idx;
        dist_next.red      = head.red;
        dist_next.green    = head.green;
        dist_next.blue     = head.blue;
        dist_next.sq_red   = SQ_W'(dr) * SQ_W'(dr);
        dist_next.sq_green = SQ_W'(dg) * SQ_W'(dg);
        dist_next.sq_blue  = SQ_W'(db) * SQ_W'(db);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg.valid <= 1'b0;
        end else begin
            dist_reg.valid <= dist_next.valid;
        end
        dist_reg.skip     <= dist_next.skip;
        dist_reg.idx      <= dist_next.idx;
        dist_reg.red      <= dist_next.red;
        dist_reg.green    <= dist_next.green;
        dist_reg.blue     <= dist_next.blue;
        dist_reg.sq_red   <= dist_next.sq_red;
        dist_reg.sq_green <= dist_next.sq_green;
        dist_reg.sq_blue  <= dist_next.sq_blue;
    end

    assign dist_q = dist_reg;

endmodule

`default_nettype wire

>>> rtl/npcs_best.sv
`default_nettype none

module npcs_best
    import npcs_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  init,
    input  wire logic  indexed,
    input  wire dist_t dist_in,
    output best_t      best_q
);

    best_t best_reg;
    best_t best_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]  sq_red_reg, sq_red_next;
    logic [SQ_W-1:0]  sq_green_reg, sq_green_next;
    logic [SQ_W-1:0]  sq_blue_reg, sq_blue_next;
    logic [SUM_W-1:0] sum;
    logic             take;

    always_comb begin
        best_next     = best_reg;
        sum_next      = sum_reg;
        sq_red_next   = sq_red_reg;
        sq_green_next = sq_green_reg;
        sq_blue_next  = sq_blue_reg;
        sum  = SUM_W'(dist_in.sq_red) + SUM_W'(dist_in.sq_green) + SUM_W'(dist_in.sq_blue);
        take = dist_in.valid & ~dist_in.skip;
        if (init) begin
            best_next.found = 1'b0;
        end else if (take) begin
            best_next.found = 1'b1;
            if (indexed) begin
                // first strict minimum of the total distance wins
                if (!best_reg.found || sum < sum_reg) begin
                    sum_next          = sum;
                    best_next.idx_red = dist_in.idx;
                    best_next.red     = dist_in.red;
                    best_next.green   = dist_in.green;
                    best_next.blue    = dist_in.blue;
                end
            end else begin
                if (!best_reg.found || dist_in.sq_red < sq_red_reg) begin
                    sq_red_next       = dist_in.sq_red;
                    best_next.idx_red = dist_in.idx;
                    best_next.red     = dist_in.red;
                end
                if (!best_reg.found || dist_in.sq_green < sq_green_reg) begin
                    sq_green_next       = dist_in.sq_green;
                    best_next.idx_green = dist_in.idx;
                    best_next.green     = dist_in.green;
                end
                if (!best_reg.found || dist_in.sq_blue < sq_blue_reg) begin
                    sq_blue_next       = dist_in.sq_blue;
                    best_next.idx_blue = dist_in.idx;
                    best_next.blue     = dist_in.blue;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg.found <= 1'b0;
        end else begin
            best_reg.found <= best_next.found;
        end
        best_reg.idx_red   <= best_next.idx_red;
        best_reg.idx_green <= best_next.idx_green;
        best_reg.idx_blue  <= best_next.idx_blue;
        best_reg.red       <= best_next.red;
        best_reg.green     <= best_next.green;
        best_reg.blue      <= best_next.blue;
        sum_reg            <= sum_next;
        sq_red_reg         <= sq_red_next;
        sq_green_reg       <= sq_green_next;
        sq_blue_reg        <= sq_blue_next;
    end

    assign best_q = best_reg;

endmodule

`default_nettype wire

>>> rtl/nearest_palette_color_search.sv
// Nearest palette color search.
// Input stream (s_*): s_tuser selects the command. A load transfer writes one
// palette entry; a load with an index at or above PALETTE_ENTRIES is dropped.
// A query transfer searches the palette and produces one result transfer on m_*.
// The palette lives in a ring of cells. A query rotates the ring one full turn,
// and the head cell feeds a two-stage distance and best-match pipeline. After
// the turn a drain state lets the pipeline settle, and the emit state loads the
// result register; s_tready stays low from the query transfer until then, so a
// new query is taken only after the last one is done. Loads sustain one per
// cycle while no query is in progress.
// Indexed mode scans min(255, PALETTE_ENTRIES) entries, direct-add mode 16,
// direct-or mode all of them; the turn length is the same in every mode.
// The result register holds a finished result while m_tready is low; the block
// keeps taking loads and queries, but a query finishing behind a stalled
// result waits until that result is taken.
// Configuration writes on cfg_* are always ready and must be issued idle.
// Reset clears control state and the configuration registers; palette
// contents are undefined until loaded. No clearing pass is run.
`default_nettype none

module nearest_palette_color_search
    import npcs_pkg::*;
#(
    parameter int PALETTE_ENTRIES = DEFAULT_PALETTE_ENTRIES
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // entry_index[7:0], red[23:8], green[39:24], blue[55:40], excluded[56],
    // use_exclusions[57], zero fill [63:58]
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    // command[0]
    input  wire logic                   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // pixel_value[31:0], match_red[47:32], match_green[63:48],
    // match_blue[79:64], found[80], zero fill [87:81]
    output logic [M_TDATA_W-1:0]        m_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);
    localparam int N_INDEXED = (INDEXED_CELLS < PALETTE_ENTRIES) ?
                               INDEXED_CELLS : PALETTE_ENTRIES;
    localparam int N_ADD = (DIRECT_ADD_CELLS < PALETTE_ENTRIES) ?
                           DIRECT_ADD_CELLS : PALETTE_ENTRIES;
    localparam int N_OR = (DIRECT_OR_CELLS < PALETTE_ENTRIES) ?
                          DIRECT_OR_CELLS : PALETTE_ENTRIES;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    logic [1:0]          mode_reg;
    logic [PIXEL_W-1:0]  red_bits_reg, green_bits_reg, blue_bits_reg;

    logic [CHAN_W-1:0] tgt_red_reg, tgt_green_reg, tgt_blue_reg;
    logic              use_ex_reg;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // input fields
    logic [ENTRY_IDX_W-1:0] in_idx;
    entry_t                 in_entry;
    logic                   in_use_ex;
    logic                   s_accept, load_go, query_go;

    assign in_idx         = s_tdata[7:0];
    assign in_entry.red   = s_tdata[23:8];
    assign in_entry.green = s_tdata[39:24];
    assign in_entry.blue  = s_tdata[55:40];
    assign in_entry.excl  = s_tdata[56];
    assign in_use_ex      = s_tdata[57];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid & s_tready;
    assign load_go  = s_accept & (s_tuser == CMD_LOAD) &
                      ({1'b0, in_idx} < (ENTRY_IDX_W + 1)'(PALETTE_ENTRIES));
    assign query_go = s_accept & (s_tuser == CMD_QUERY);

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_INDEXED;
            red_bits_reg   <= '0;
            green_bits_reg <= '0;
            blue_bits_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_COLOR_MODE: mode_reg       <= cfg_data[1:0];
                REG_RED_MASK:   red_bits_reg   <= cfg_data;
                REG_GREEN_MASK: green_bits_reg <= cfg_data;
                REG_BLUE_MASK:  blue_bits_reg  <= cfg_data;
                default:        mode_reg       <= mode_reg;
            endcase
        end
    end

    logic indexed;
    logic [CNT_W-1:0] scan_len;

    assign indexed = (mode_reg == MODE_INDEXED);

    always_comb begin
        if (indexed) begin
            scan_len = CNT_W'(N_INDEXED);
        end else if (mode_reg == MODE_DIRECT_ADD) begin
            scan_len = CNT_W'(N_ADD);
        end else begin
            scan_len = CNT_W'(N_OR);
        end
    end

    // palette ring: cell 0 is the head, each cell takes from its upper neighbor
    entry_t cell_q [PALETTE_ENTRIES];
    logic   shift_en;

    assign shift_en = (state_reg == ST_SCAN);

    for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
        npcs_cell u_cell (
            .aclk      (aclk),
            .shift_en  (shift_en),
            .load_en   (load_go && (in_idx[IDX_W-1:0] == IDX_W'(i))),
            .shift_in  (cell_q[(i + 1) % PALETTE_ENTRIES]),
            .load_data (in_entry),
            .entry_q   (cell_q[i])
        );
    end

    // query target
    always_ff @(posedge aclk) begin
        if (query_go) begin
            tgt_red_reg   <= in_entry.red;
            tgt_green_reg <= in_entry.green;
            tgt_blue_reg  <= in_entry.blue;
            use_ex_reg    <= in_use_ex;
        end
    end

    dist_t dist_bus;
    best_t best;

    npcs_dist u_dist (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (shift_en && ({1'b0, cnt_reg} < (IDX_W + 1)'(scan_len))),
        .honor_excl   (use_ex_reg & indexed),
        .in_idx       (ENTRY_IDX_W'(cnt_reg)),
        .head         (cell_q[0]),
        .target_red   (tgt_red_reg),
        .target_green (tgt_green_reg),
        .target_blue  (tgt_blue_reg),
        .dist_q       (dist_bus)
    );

    npcs_best u_best (
        .aclk    (aclk),
        .aresetn (aresetn),
        .init    (query_go),
        .indexed (indexed),
        .dist_in (dist_bus),
        .best_q  (best)
    );

    // pixel assembly: in the direct modes each channel's code is built from its own winning index
    logic [PIXEL_W-1:0] red_low, green_low, blue_low, pixel;
    logic [PIXEL_W-1:0] out_pixel;
    logic [CHAN_W-1:0]  out_red, out_green, out_blue;
    logic               out_found;
    logic               add_mode;

    function automatic logic [PIXEL_W-1:0] cell_code(input logic [ENTRY_IDX_W-1:0] idx,
                                                     input logic               add,
                                                     input logic [PIXEL_W-1:0] lr,
                                                     input logic [PIXEL_W-1:0] lg,
                                                     input logic [PIXEL_W-1:0] lb);
        logic [PIXEL_W-1:0] r, g, b;
        r = PIXEL_W'(idx) * lr;
        g = PIXEL_W'(idx) * lg;
        b = PIXEL_W'(idx) * lb;
        return add ? (r + g + b) : (r | g | b);
    endfunction

    assign red_low   = low_bit(red_bits_reg);
    assign green_low = low_bit(green_bits_reg);
    assign blue_low  = low_bit(blue_bits_reg);
    assign add_mode  = (mode_reg == MODE_DIRECT_ADD);

    always_comb begin
        pixel = (cell_code(best.idx_red, add_mode, red_low, green_low, blue_low)
                 & red_bits_reg)
              | (cell_code(best.idx_green, add_mode, red_low, green_low, blue_low)
                 & green_bits_reg)
              | (cell_code(best.idx_blue, add_mode, red_low, green_low, blue_low)
                 & blue_bits_reg);
        if (indexed) begin
            out_found = best.found;
            out_pixel = best.found ? PIXEL_W'(best.idx_red) : '0;
            out_red   = best.found ? best.red   : '0;
            out_green = best.found ? best.green : '0;
            out_blue  = best.found ? best.blue  : '0;
        end else begin
            out_found = 1'b1;
            out_pixel = pixel;
            out_red   = best.red;
            out_green = best.green;
            out_blue  = best.blue;
        end
    end

    // sequencer and result register
    logic emit_go;

    assign emit_go = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (query_go) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_reg == IDX_W'(PALETTE_ENTRIES - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_go) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, out_found, out_blue, out_green,
                                     out_red, out_pixel};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // ring must sit at its home position whenever loads can land
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> cnt_reg == '0)
        else $error("ring position not at home while idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !dist_bus.valid)
        else $error("distance pipeline busy while accepting input");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> !dist_bus.valid)
        else $error("result emitted before pipeline drained");

    assert property (@(posedge aclk) disable iff (!aresetn)
        emit_go |=> m_tvalid)
        else $error("finished query result lost");
`endif

endmodule

`default_nettype wire

>>> dv/palette_search_checker.sv
module palette_search_checker
    import npcs_pkg::*;
#(
    parameter int PALETTE_ENTRIES = DEFAULT_PALETTE_ENTRIES
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    input  wire logic                   s_tuser,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [M_TDATA_W-1:0]   m_tdata,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int unsigned                 errors,
    output int unsigned                 pending
);

    localparam logic [31:0] FULL_SCALE_DIST = 32'd65535 * 32'd65535;

    typedef struct packed {
        logic [31:0] pixel;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        found;
    } match_t;

    // palette shadow, never cleared: entries are loaded before any search reads them
    logic [15:0] pal_red   [PALETTE_ENTRIES];
    logic [15:0] pal_green [PALETTE_ENTRIES];
    logic [15:0] pal_blue  [PALETTE_ENTRIES];
    logic        pal_skip  [PALETTE_ENTRIES];

    logic [1:0]  color_mode;
    logic [31:0] red_bits;
    logic [31:0] green_bits;
    logic [31:0] blue_bits;

    match_t expected_matches[$];

    function automatic logic [31:0] chan_dist(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] d;
        d = (a >= b) ? {16'd0, a - b} : {16'd0, b - a};
        return d * d;
    endfunction

    function automatic logic [31:0] lowest_one(input logic [31:0] m);
        return m & (32'd0 - m);
    endfunction

    // pixel code of palette cell idx in the direct modes, wrapped to 32 bits
    function automatic logic [31:0] cell_code(input int unsigned idx, input logic add);
        logic [31:0] k;
        logic [31:0] r;
        logic [31:0] g;
        logic [31:0] b;
        k = idx;
        r = k * lowest_one(red_bits);
        g = k * lowest_one(green_bits);
        b = k * lowest_one(blue_bits);
        return add ? (r + g + b) : (r | g | b);
    endfunction

    function automatic match_t nearest_match(input logic [15:0] tr, input logic [15:0] tg,
                                             input logic [15:0] tb, input logic honor);
        match_t      res;
        logic [33:0] total;
        logic [33:0] best_dist;
        logic [31:0] br;
        logic [31:0] bg;
        logic [31:0] bb;
        logic        hit;
        logic        add;
        int unsigned cells;
        int unsigned best_i;
        int unsigned ri;
        int unsigned gi;
        int unsigned bi;
        res = '0;
        if (color_mode == MODE_INDEXED) begin
            cells = (INDEXED_CELLS < PALETTE_ENTRIES) ? INDEXED_CELLS : PALETTE_ENTRIES;
            hit = 1'b0;
            best_dist = '0;
            best_i = 0;
            for (int unsigned i = 0; i < cells; i++) begin
                if (!(honor && pal_skip[i])) begin
                    total = {2'b00, chan_dist(tr, pal_red[i])}
                          + {2'b00, chan_dist(tg, pal_green[i])}
                          + {2'b00, chan_dist(tb, pal_blue[i])};
                    // strictly closer only: the first of equal distances wins
                    if (!hit || total < best_dist) begin
                        hit = 1'b1;
                        best_dist = total;
                        best_i = i;
                    end
                end
            end
            if (hit) begin
                res.pixel = best_i;
                res.red   = pal_red[best_i];
                res.green = pal_green[best_i];
                res.blue  = pal_blue[best_i];
                res.found = 1'b1;
            end
        end else begin
            add = (color_mode == MODE_DIRECT_ADD);
            cells = add ? DIRECT_ADD_CELLS : DIRECT_OR_CELLS;
            if (cells > PALETTE_ENTRIES) begin
                cells = PALETTE_ENTRIES;
            end
            br = FULL_SCALE_DIST;
            bg = FULL_SCALE_DIST;
            bb = FULL_SCALE_DIST;
            ri = 0;
            gi = 0;
            bi = 0;
            for (int unsigned i = 0; i < cells; i++) begin
                if (chan_dist(tr, pal_red[i]) < br) begin
                    br = chan_dist(tr, pal_red[i]);
                    ri = i;
                end
                if (chan_dist(tg, pal_green[i]) < bg) begin
                    bg = chan_dist(tg, pal_green[i]);
                    gi = i;
                end
                if (chan_dist(tb, pal_blue[i]) < bb) begin
                    bb = chan_dist(tb, pal_blue[i]);
                    bi = i;
                end
            end
            res.pixel = (cell_code(ri, add) & red_bits) | (cell_code(gi, add) & green_bits)
                      | (cell_code(bi, add) & blue_bits);
            res.red   = pal_red[ri];
            res.green = pal_green[gi];
            res.blue  = pal_blue[bi];
            res.found = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin : watch
        match_t got;
        match_t want;
        if (!aresetn) begin
            color_mode = MODE_INDEXED;
            red_bits   = '0;
            green_bits = '0;
            blue_bits  = '0;
            expected_matches.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[47:32], m_tdata[63:48], m_tdata[79:64],
                       m_tdata[80]};
                if (expected_matches.size() == 0) begin
                    report_mismatch("result with no query waiting, pixel", got.pixel, '0);
                end else begin
                    want = expected_matches.pop_front();
                    if (got.pixel !== want.pixel)
                        report_mismatch("pixel_value", got.pixel, want.pixel);
                    if (got.red !== want.red)
                        report_mismatch("match_red", {16'd0, got.red}, {16'd0, want.red});
                    if (got.green !== want.green)
                        report_mismatch("match_green", {16'd0, got.green}, {16'd0, want.green});
                    if (got.blue !== want.blue)
                        report_mismatch("match_blue", {16'd0, got.blue}, {16'd0, want.blue});
                    if (got.found !== want.found)
                        report_mismatch("found", {31'd0, got.found}, {31'd0, want.found});
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_COLOR_MODE: color_mode = cfg_data[1:0];
                    REG_RED_MASK:   red_bits   = cfg_data;
                    REG_GREEN_MASK: green_bits = cfg_data;
                    REG_BLUE_MASK:  blue_bits  = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_LOAD) begin
                    // drop loads beyond the palette
                    if (int'(s_tdata[7:0]) < PALETTE_ENTRIES) begin
                        pal_red[s_tdata[7:0]]   = s_tdata[23:8];
                        pal_green[s_tdata[7:0]] = s_tdata[39:24];
                        pal_blue[s_tdata[7:0]]  = s_tdata[55:40];
                        pal_skip[s_tdata[7:0]]  = s_tdata[56];
                    end
                end else begin
                    expected_matches.push_back(nearest_match(s_tdata[23:8], s_tdata[39:24],
                                                             s_tdata[55:40], s_tdata[57]));
                end
            end
        end
        pending = expected_matches.size();
    end

endmodule

>>> dv/tb.sv
module tb
    import npcs_pkg::*;
;

    localparam int PALETTE_SIZE      = DEFAULT_PALETTE_ENTRIES;
    localparam int SETTLE_CYCLES     = PALETTE_SIZE + 16;
    localparam int LONG_STALL        = 1500;
    localparam int WATCHDOG_LIMIT    = 10000;
    localparam int PHASES            = 8;
    localparam int ITEMS_PER_PHASE   = 54;
    localparam int POOL_SIZE         = 8;
    localparam int BLACK_ENTRY       = 0;
    localparam int WHITE_ENTRY       = 20;
    localparam int TWIN_ENTRY        = 21;

    localparam logic [1:0] MODE_DIRECT_OR       = 2'd2;
    localparam logic [1:0] MODE_DIRECT_OR_ALIAS = 2'd3;

    localparam logic [15:0] TWIN_RED   = 16'h1234;
    localparam logic [15:0] TWIN_GREEN = 16'h5678;
    localparam logic [15:0] TWIN_BLUE  = 16'h9ABC;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  index;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        excl;
        logic        use_excl;
    } palette_op_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int unsigned open_queries;
    int unsigned fail_count;
    int unsigned quiet_cycles;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned stalls_asked;
    logic [1:0]  cur_mode;

    logic [15:0] pool_red   [POOL_SIZE];
    logic [15:0] pool_green [POOL_SIZE];
    logic [15:0] pool_blue  [POOL_SIZE];

    nearest_palette_color_search #(
        .PALETTE_ENTRIES(PALETTE_SIZE)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    palette_search_checker #(
        .PALETTE_ENTRIES(PALETTE_SIZE)
    ) u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .errors   (fail_count),
        .pending  (open_queries)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        @(negedge aclk);
        while (quiet_cycles < WATCHDOG_LIMIT) @(negedge aclk);
        $display("nearest_palette_color_search verification failed");
        $finish;
    end

    // result side: random backpressure, plus one long hold-off on request
    initial begin : result_sink
        int unsigned stalls_served;
        stalls_served = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (stalls_served != stalls_asked) begin
                stalls_served++;
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [15:0] pick_level();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic palette_op_t load_op(input logic [7:0] idx, input logic [15:0] r,
                                            input logic [15:0] g, input logic [15:0] b,
                                            input logic skip);
        palette_op_t op;
        op = '0;
        op.cmd      = CMD_LOAD;
        op.index    = idx;
        op.red      = r;
        op.green    = g;
        op.blue     = b;
        op.excl     = skip;
        op.use_excl = 1'($urandom_range(1));
        return op;
    endfunction

    function automatic palette_op_t query_op(input logic [15:0] r, input logic [15:0] g,
                                             input logic [15:0] b, input logic honor);
        palette_op_t op;
        op = '0;
        op.cmd      = CMD_QUERY;
        op.index    = 8'($urandom_range(255));
        op.red      = r;
        op.green    = g;
        op.blue     = b;
        op.excl     = 1'($urandom_range(1));
        op.use_excl = honor;
        return op;
    endfunction

    // targets and loads often built around recent colors, so ties and exact hits occur
    task automatic next_random_op(output palette_op_t op);
        int unsigned slot;
        logic [7:0]  idx;
        slot = $urandom_range(POOL_SIZE - 1);
        if ($urandom_range(99) < 40) begin
            case ($urandom_range(4))
                0, 1: op = query_op(pool_red[slot], pool_green[slot], pool_blue[slot],
                                    1'($urandom_range(1)));
                2: op = query_op(pool_red[slot] + 16'($urandom_range(8)) - 16'd4,
                                 pool_green[slot] + 16'($urandom_range(8)) - 16'd4,
                                 pool_blue[slot] + 16'($urandom_range(8)) - 16'd4,
                                 1'($urandom_range(1)));
                default: op = query_op(pick_level(), pick_level(), pick_level(),
                                       1'($urandom_range(1)));
            endcase
        end else begin
            if (cur_mode == MODE_DIRECT_ADD && $urandom_range(1) == 1)
                idx = 8'($urandom_range(DIRECT_ADD_CELLS - 1));
            else
                idx = 8'($urandom_range(255));
            if ($urandom_range(9) < 3) begin
                op = load_op(idx, pool_red[slot], pool_green[slot], pool_blue[slot],
                             $urandom_range(99) < 30);
            end else begin
                op = load_op(idx, pick_level(), pick_level(), pick_level(),
                             $urandom_range(99) < 30);
                pool_red[slot]   = op.red;
                pool_green[slot] = op.green;
                pool_blue[slot]  = op.blue;
            end
        end
    endtask

    task automatic push_op(input palette_op_t op);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op.cmd;
        s_tdata  <= {6'd0, op.use_excl, op.excl, op.blue, op.green, op.red, op.index};
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (open_queries != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    // a trailing load may still be in flight after the last result
    task automatic drain();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [1:0] mode, input logic [31:0] rmask,
                                 input logic [31:0] gmask, input logic [31:0] bmask);
        write_reg(REG_COLOR_MODE, {30'd0, mode});
        write_reg(REG_RED_MASK, rmask);
        write_reg(REG_GREEN_MASK, gmask);
        write_reg(REG_BLUE_MASK, bmask);
        cfg_valid <= 1'b0;
        cur_mode = mode;
    endtask

    initial begin : stimulus
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic        skip;
        palette_op_t op;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_LOAD;
        cfg_valid = 1'b0;
        cfg_index = REG_COLOR_MODE;
        cfg_data  = '0;
        send_idle_pct = 21;
        recv_idle_pct = 65;
        stalls_asked  = 0;
        cur_mode      = MODE_INDEXED;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        apply_setting(MODE_INDEXED, '0, '0, '0);

        // fill every entry before any search; red of the first 16 cells stays zero
        for (int i = 0; i < PALETTE_SIZE; i++) begin
            r = (i < DIRECT_ADD_CELLS) ? 16'h0000 : pick_level();
            g = pick_level();
            b = pick_level();
            skip = ($urandom_range(3) == 0);
            if (i == BLACK_ENTRY) begin
                {r, g, b, skip} = '0;
            end else if (i == WHITE_ENTRY) begin
                {r, g, b, skip} = {16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1};
            end else if (i == TWIN_ENTRY || i == TWIN_ENTRY + 1) begin
                {r, g, b} = {TWIN_RED, TWIN_GREEN, TWIN_BLUE};
                skip = (i == TWIN_ENTRY);
            end
            push_op(load_op(8'(i), r, g, b, skip));
            pool_red[i % POOL_SIZE]   = r;
            pool_green[i % POOL_SIZE] = g;
            pool_blue[i % POOL_SIZE]  = b;
        end

        // indexed: extremes, excluded white, twin colors where the first is excluded
        push_op(query_op(16'h0000, 16'h0000, 16'h0000, 1'b1));
        push_op(query_op(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        push_op(query_op(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        push_op(query_op(TWIN_RED, TWIN_GREEN, TWIN_BLUE, 1'b1));
        push_op(query_op(TWIN_RED, TWIN_GREEN, TWIN_BLUE, 1'b0));

        // direct add: full-scale red distance everywhere keeps cell zero
        drain();
        apply_setting(MODE_DIRECT_ADD, 32'h0000F800, 32'h000007E0, 32'h0000001F);
        push_op(query_op(16'hFFFF, 16'h0000, 16'h8000, 1'b0));
        push_op(query_op(16'h0000, 16'hFFFF, 16'h0000, 1'b1));
        push_op(query_op(pick_level(), pick_level(), pick_level(), 1'b0));

        // the unused mode code behaves as direct OR; top-bit and empty masks
        drain();
        apply_setting(MODE_DIRECT_OR_ALIAS, 32'hFFFFFFFF, 32'h80000000, 32'h00000000);
        push_op(query_op(16'hFFFF, 16'hFFFF, 16'h0000, 1'b0));
        push_op(query_op(pick_level(), pick_level(), pick_level(), 1'b1));

        // exclude every indexed cell, then search with and without exclusions
        drain();
        apply_setting(MODE_INDEXED, $urandom, $urandom, $urandom);
        for (int i = 0; i < INDEXED_CELLS; i++) begin
            push_op(load_op(8'(i), pick_level(), pick_level(), pick_level(), 1'b1));
        end
        push_op(query_op(pick_level(), pick_level(), pick_level(), 1'b1));
        push_op(query_op(pick_level(), pick_level(), pick_level(), 1'b0));

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < 3) begin
                send_idle_pct = 21;
                recv_idle_pct = 65;
            end else if (phase < 6) begin
                send_idle_pct = 65;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            drain();
            case (phase)
                0: apply_setting(MODE_DIRECT_OR, 32'h00FF0000, 32'h0000FF00, 32'h000000FF);
                1: apply_setting(MODE_INDEXED, '0, '0, '0);
                2: apply_setting(MODE_DIRECT_ADD, '1, '1, '1);
                3: apply_setting(MODE_DIRECT_OR_ALIAS, $urandom, $urandom, $urandom);
                4: apply_setting(MODE_INDEXED, $urandom, $urandom, $urandom);
                5: apply_setting(MODE_DIRECT_ADD, $urandom, $urandom, $urandom);
                6: apply_setting(MODE_DIRECT_OR, 32'h3FF00000, 32'h000FFC00, 32'h000003FF);
                default: apply_setting(MODE_DIRECT_ADD, 32'h0000F800, 32'h000007E0,
                                       32'h0000001F);
            endcase
            // hold results back long enough for the block to back up its input
            if (phase == 4)
                stalls_asked <= stalls_asked + 1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (phase == 2 && k == ITEMS_PER_PHASE / 2)
                    wait_results_done();
                next_random_op(op);
                push_op(op);
            end
        end

        drain();
        if (fail_count == 0)
            $display("nearest_palette_color_search verification clean");
        else
            $display("nearest_palette_color_search verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/npcs_pkg.sv
rtl/npcs_cell.sv
rtl/npcs_dist.sv
rtl/npcs_best.sv
rtl/nearest_palette_color_search.sv
dv/palette_search_checker.sv
dv/tb.sv
